// ===== rtl/core/ctrr_pkg.sv =====
// ----------------------------------------------------------------------------
// ctrr_pkg
// Types and constants shared by the transport receiver: codes, the job
// descriptor that travels from the front to the back, and queue status.
// ----------------------------------------------------------------------------
package ctrr_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_FRAME = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_FLOW    = 2'd1,
    KIND_DONE    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TIMEOUT  = 3'd1,
    ST_INVALID  = 3'd2,
    ST_OVERRUN  = 3'd3,
    ST_SEQUENCE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_CONSEC = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    REG_RESPONSE_ID    = 3'd0,
    REG_REQUEST_ID     = 3'd1,
    REG_PAD_VALUE      = 3'd2,
    REG_CAPACITY       = 3'd3,
    REG_TIMEOUT_BUDGET = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    STEP_PAY  = 2'd0,
    STEP_FC   = 2'd1,
    STEP_FIN  = 2'd2
  } step_t;

  localparam logic [3:0] FT_SINGLE      = 4'd0;
  localparam logic [3:0] FT_FIRST       = 4'd1;
  localparam logic [3:0] FT_CONSEC      = 4'd2;
  localparam logic [7:0] FC_CLEAR       = 8'h30;
  localparam logic [7:0] FC_BLOCK_SIZE  = 8'h00;
  localparam logic [7:0] FC_ST_MIN      = 8'h00;
  localparam logic [3:0] SF_PAYLOAD_MAX = 4'd7;
  localparam logic [2:0] FF_PAYLOAD     = 3'd6;
  localparam logic [2:0] CF_PAYLOAD_MAX = 3'd7;
  localparam logic [2:0] FC_LAST_BYTE   = 3'd7;
  localparam logic [3:0] DLC_FULL       = 4'd8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [6:0][7:0] data;
    logic [2:0]      count;
    logic [11:0]     base;
    logic            fc;
    logic [7:0]      pad;
    logic            fin;
    status_t         status;
    logic [11:0]     length;
  } job_t;

  typedef struct packed {
    logic                full;
    logic                empty;
    logic [QUEUE_AW:0]   level;
  } queue_status_t;

endpackage

// ===== rtl/core/can_transport_reassembling_receiver.sv =====
// ----------------------------------------------------------------------------
// can_transport_reassembling_receiver
// Reassembles one segmented transport message from received CAN frames and
// emits payload bytes, flow-control bytes and a completion status.
// ----------------------------------------------------------------------------
//  channel  | direction | beat contents
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | one start, frame or tick item
//  m_axis   | out       | payload byte, flow-control byte or completion
//  cfg      | in        | register write, taken in the same cycle
//
// An item is taken every cycle while the four-entry job queue has room; the
// front settles session state in the cycle it takes the item.
// While m_tready is high the back sends one beat per cycle, up to 14 beats
// per frame, so the job expansion sets the sustained frame rate.
// Reset is synchronous and clears session state, queue and output valid.
// The output register holds while m_tready is low; the queue then fills and
// s_tready falls.
module can_transport_reassembling_receiver #(
  parameter int MAX_LENGTH = 4095
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [28:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // frame_id, frame_dlc, byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7
  input  logic [103:0] s_tdata,
  // operation
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // byte_value, byte_index, status, message_length
  output logic [39:0]  m_tdata,
  // kind
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);

  logic                    accept;
  logic                    push;
  logic                    pop;
  ctrr_pkg::job_t          push_job;
  ctrr_pkg::job_t          head;
  ctrr_pkg::queue_status_t q_status;
  logic [7:0][7:0]         frame_bytes;

  assign s_tready    = !q_status.full;
  assign accept      = s_tvalid && s_tready;
  assign frame_bytes = s_tdata[96:33];

  ctrr_front #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .operation   (s_tuser),
    .frame_id    (s_tdata[28:0]),
    .frame_dlc   (s_tdata[32:29]),
    .frame_bytes (frame_bytes),
    .push        (push),
    .job         (push_job)
  );

  ctrr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  ctrr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .avail    (!q_status.empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full || pop)
    else $error("job pushed into a full queue");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.level <= (ctrr_pkg::QUEUE_AW+1)'(ctrr_pkg::QUEUE_DEPTH))
    else $error("queue level above depth");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ctrr_pkg::KIND_DONE |-> m_tlast)
    else $error("completion beat without last");

  a_status_on_done_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ctrr_pkg::KIND_DONE |-> m_tdata[22:20] == ctrr_pkg::ST_OK)
    else $error("status set on a byte beat");

endmodule

// ===== rtl/core/ctrr_front.sv =====
// ----------------------------------------------------------------------------
// ctrr_front
// Holds configuration and session state, classifies each accepted item and
// pushes one job for each item that causes result beats, describing them.
// ----------------------------------------------------------------------------
module ctrr_front #(
  parameter int MAX_LENGTH = 4095
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [28:0]       cfg_data,
  input  logic              accept,
  input  logic [1:0]        operation,
  input  logic [28:0]       frame_id,
  input  logic [3:0]        frame_dlc,
  input  logic [7:0][7:0]   frame_bytes,
  output logic              push,
  output ctrr_pkg::job_t    job
);

  localparam logic [11:0] MaxLen = 12'(MAX_LENGTH);

  logic [28:0]       response_id;
  logic [7:0]        pad_value;
  logic [11:0]       capacity;
  logic [15:0]       timeout_budget;

  ctrr_pkg::phase_t  phase, phase_next;
  logic [15:0]       time_left, time_left_next;
  logic [11:0]       total_length, total_length_next;
  logic [11:0]       received_count, received_count_next;
  logic [3:0]        expected_sequence, expected_sequence_next;

  logic [3:0]        dlc_eff;
  logic [11:0]       limit;
  logic [3:0]        pci_type;
  logic [3:0]        pci_low;
  logic [11:0]       ff_length;
  logic [11:0]       remaining;
  logic [2:0]        take;
  logic [11:0]       count_sum;
  logic [15:0]       tick_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      response_id    <= '0;
      pad_value      <= '0;
      capacity       <= 12'd4095;
      timeout_budget <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ctrr_pkg::REG_RESPONSE_ID:    response_id    <= cfg_data;
        ctrr_pkg::REG_PAD_VALUE:      pad_value      <= cfg_data[7:0];
        ctrr_pkg::REG_CAPACITY:       capacity       <= cfg_data[11:0];
        ctrr_pkg::REG_TIMEOUT_BUDGET: timeout_budget <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= ctrr_pkg::PH_IDLE;
      time_left         <= '0;
      total_length      <= '0;
      received_count    <= '0;
      expected_sequence <= 4'd1;
    end else begin
      phase             <= phase_next;
      time_left         <= time_left_next;
      total_length      <= total_length_next;
      received_count    <= received_count_next;
      expected_sequence <= expected_sequence_next;
    end
  end

  always_comb begin
    dlc_eff   = (frame_dlc > ctrr_pkg::DLC_FULL) ? ctrr_pkg::DLC_FULL : frame_dlc;
    limit     = (capacity < MaxLen) ? capacity : MaxLen;
    pci_type  = frame_bytes[0][7:4];
    pci_low   = frame_bytes[0][3:0];
    ff_length = {pci_low, frame_bytes[1]};
    remaining = (total_length > received_count) ? (total_length - received_count) : 12'd0;
    take      = (remaining < 12'(ctrr_pkg::CF_PAYLOAD_MAX)) ? remaining[2:0]
                                                           : ctrr_pkg::CF_PAYLOAD_MAX;
    count_sum = received_count + 12'(take);
    tick_left = (time_left != 16'd0) ? (time_left - 16'd1) : time_left;

    phase_next             = phase;
    time_left_next         = time_left;
    total_length_next      = total_length;
    received_count_next    = received_count;
    expected_sequence_next = expected_sequence;
    push                   = 1'b0;
    job                    = '0;
    job.pad                = pad_value;
    job.status             = ctrr_pkg::ST_OK;
    for (int k = 0; k < 7; k++) begin
      job.data[k] = frame_bytes[k + 1];
    end

    if (accept) begin
      unique case (operation)
        ctrr_pkg::OP_START: begin
          phase_next             = ctrr_pkg::PH_FIRST;
          time_left_next         = timeout_budget;
          total_length_next      = '0;
          received_count_next    = '0;
          expected_sequence_next = 4'd1;
          if (timeout_budget == 16'd0) begin
            push       = 1'b1;
            job.fin    = 1'b1;
            job.status = ctrr_pkg::ST_TIMEOUT;
            phase_next = ctrr_pkg::PH_IDLE;
          end
        end
        ctrr_pkg::OP_TICK: begin
          if (phase != ctrr_pkg::PH_IDLE) begin
            time_left_next = tick_left;
            if (tick_left == 16'd0) begin
              push       = 1'b1;
              job.fin    = 1'b1;
              job.status = ctrr_pkg::ST_TIMEOUT;
              phase_next = ctrr_pkg::PH_IDLE;
            end
          end
        end
        ctrr_pkg::OP_FRAME: begin
          if (phase != ctrr_pkg::PH_IDLE && frame_id == response_id) begin
            push    = 1'b1;
            job.fin = 1'b1;
            priority if (dlc_eff == 4'd0) begin
              job.status = ctrr_pkg::ST_INVALID;
            end else if (phase == ctrr_pkg::PH_FIRST) begin
              priority if (pci_type == ctrr_pkg::FT_SINGLE) begin
                priority if (pci_low == 4'd0 || pci_low > ctrr_pkg::SF_PAYLOAD_MAX ||
                             pci_low > dlc_eff - 4'd1) begin
                  job.status = ctrr_pkg::ST_INVALID;
                end else if (12'(pci_low) > limit) begin
                  job.status = ctrr_pkg::ST_OVERRUN;
                end else begin
                  job.count  = pci_low[2:0];
                  job.length = 12'(pci_low);
                end
              end else if (pci_type != ctrr_pkg::FT_FIRST || dlc_eff != ctrr_pkg::DLC_FULL) begin
                job.status = ctrr_pkg::ST_INVALID;
              end else begin
                total_length_next = ff_length;
                priority if (ff_length <= 12'd7) begin
                  job.status = ctrr_pkg::ST_INVALID;
                end else if (ff_length > limit) begin
                  job.status = ctrr_pkg::ST_OVERRUN;
                end else begin
                  for (int k = 0; k < 6; k++) begin
                    job.data[k] = frame_bytes[k + 2];
                  end
                  job.data[6]            = '0;
                  job.count              = ctrr_pkg::FF_PAYLOAD;
                  job.fc                 = 1'b1;
                  job.fin                = 1'b0;
                  received_count_next    = 12'(ctrr_pkg::FF_PAYLOAD);
                  expected_sequence_next = 4'd1;
                end
              end
            end else begin
              priority if (pci_type != ctrr_pkg::FT_CONSEC) begin
                job.status = ctrr_pkg::ST_INVALID;
              end else if (pci_low != expected_sequence) begin
                job.status = ctrr_pkg::ST_SEQUENCE;
              end else if (dlc_eff < 4'(take) + 4'd1) begin
                job.status = ctrr_pkg::ST_INVALID;
              end else begin
                job.count              = take;
                job.base               = received_count;
                received_count_next    = count_sum;
                expected_sequence_next = expected_sequence + 4'd1;
                job.fin                = (count_sum >= total_length);
                job.length             = count_sum;
              end
            end
            if (job.fin) begin
              phase_next = ctrr_pkg::PH_IDLE;
            end else begin
              phase_next = ctrr_pkg::PH_CONSEC;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/ctrr_queue.sv =====
// ----------------------------------------------------------------------------
// ctrr_queue
// Short first-in first-out queue of job descriptors between front and back.
// ----------------------------------------------------------------------------
module ctrr_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  ctrr_pkg::job_t          push_job,
  input  logic                    pop,
  output ctrr_pkg::job_t          head,
  output ctrr_pkg::queue_status_t status
);

  localparam int AW = ctrr_pkg::QUEUE_AW;

  ctrr_pkg::job_t  entries [ctrr_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     level;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        level <= level + (AW+1)'(1);
      end else if (pop && !push) begin
        level <= level - (AW+1)'(1);
      end
    end
  end

  assign head         = entries[rd_ptr];
  assign status.level = level;
  assign status.full  = (level == (AW+1)'(ctrr_pkg::QUEUE_DEPTH));
  assign status.empty = (level == '0);

endmodule

// ===== rtl/core/ctrr_back.sv =====
// ----------------------------------------------------------------------------
// ctrr_back
// Expands each job into output register beats, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ctrr_back (
  input  logic                    clk,
  input  logic                    rst,
  input  ctrr_pkg::job_t          head,
  input  logic                    avail,
  output logic                    pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [39:0]             m_tdata,
  output logic [1:0]              m_tuser,
  output logic                    m_tlast
);

  ctrr_pkg::job_t   cur;
  logic             busy;
  ctrr_pkg::step_t  step;
  logic [2:0]       idx;

  logic             load;
  logic             beat_last;
  logic [1:0]       beat_kind;
  logic [7:0]       beat_value;
  logic [11:0]      beat_index;
  logic [2:0]       beat_status;
  logic [11:0]      beat_length;
  ctrr_pkg::step_t  step_next;
  ctrr_pkg::step_t  first_step;

  assign load = !m_tvalid || m_tready;
  assign pop  = avail && (!busy || (load && beat_last));

  always_comb begin
    beat_kind   = ctrr_pkg::KIND_DONE;
    beat_value  = '0;
    beat_index  = '0;
    beat_status = ctrr_pkg::ST_OK;
    beat_length = '0;
    beat_last   = 1'b1;
    step_next   = step;
    unique case (step)
      ctrr_pkg::STEP_PAY: begin
        beat_kind  = ctrr_pkg::KIND_PAYLOAD;
        beat_value = cur.data[idx];
        beat_index = cur.base + 12'(idx);
        beat_last  = (idx == cur.count - 3'd1) && !cur.fc && !cur.fin;
        if (idx == cur.count - 3'd1) begin
          step_next = cur.fc ? ctrr_pkg::STEP_FC : ctrr_pkg::STEP_FIN;
        end
      end
      ctrr_pkg::STEP_FC: begin
        beat_kind  = ctrr_pkg::KIND_FLOW;
        priority if (idx == 3'd0) begin
          beat_value = ctrr_pkg::FC_CLEAR;
        end else if (idx == 3'd1) begin
          beat_value = ctrr_pkg::FC_BLOCK_SIZE;
        end else if (idx == 3'd2) begin
          beat_value = ctrr_pkg::FC_ST_MIN;
        end else begin
          beat_value = cur.pad;
        end
        beat_index = 12'(idx);
        beat_last  = (idx == ctrr_pkg::FC_LAST_BYTE) && !cur.fin;
        if (idx == ctrr_pkg::FC_LAST_BYTE) begin
          step_next = ctrr_pkg::STEP_FIN;
        end
      end
      default: begin
        beat_status = cur.status;
        beat_length = cur.length;
      end
    endcase

    if (head.count != 3'd0) begin
      first_step = ctrr_pkg::STEP_PAY;
    end else if (head.fc) begin
      first_step = ctrr_pkg::STEP_FC;
    end else begin
      first_step = ctrr_pkg::STEP_FIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
      step     <= ctrr_pkg::STEP_FIN;
      idx      <= '0;
    end else begin
      if (load) begin
        m_tvalid <= busy;
      end
      if (pop) begin
        busy <= 1'b1;
        step <= first_step;
        idx  <= '0;
      end else if (load && busy) begin
        if (beat_last) begin
          busy <= 1'b0;
        end else begin
          step <= step_next;
          idx  <= (step_next != step) ? 3'd0 : idx + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (load && busy) begin
      m_tdata <= {5'd0, beat_length, beat_status, beat_index, beat_value};
      m_tuser <= beat_kind;
      m_tlast <= beat_last;
    end
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CAN transport reassembling receiver. Start,
// frame and tick beats go in on the input stream. A scoreboard class keeps its
// own copy of the session state, predicts the payload, flow-control and
// completion beats, and compares them in order with the output stream. Both
// sides idle at random. One long receiver stall backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import ctrr_pkg::*;

  localparam int MSG_LIMIT = 4095;
  localparam int SETTLE = 60;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef logic [7:0][7:0] frame_bytes_t;

  typedef enum int {
    FAULT_NONE      = 0,
    FAULT_SEQ       = 1,
    FAULT_TYPE      = 2,
    FAULT_DLC       = 3,
    FAULT_ABANDON   = 4,
    FAULT_FIRST_DLC = 5
  } fault_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  value;
    logic [11:0] index;
    status_t     status;
    logic [11:0] length;
    logic        last;
  } beat_t;

  class reassembly_scoreboard;
    logic [28:0] rsp_id;
    logic [7:0]  pad;
    logic [11:0] capacity;
    logic [15:0] budget;
    phase_t      phase;
    logic [15:0] time_left;
    logic [11:0] total_len;
    logic [11:0] rcvd;
    logic [3:0]  next_seq;
    beat_t       awaited[$];
    beat_t       fresh[$];
    int          mismatches;
    int          beats_seen;
    int          endings[5];

    function new();
      rsp_id = '0;
      pad = '0;
      capacity = 12'd4095;
      budget = 16'd1000;
      phase = PH_IDLE;
      time_left = '0;
      total_len = '0;
      rcvd = '0;
      next_seq = 4'd1;
      mismatches = 0;
      beats_seen = 0;
      foreach (endings[i]) endings[i] = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [28:0] val);
      case (idx)
        REG_RESPONSE_ID:    rsp_id = val;
        REG_PAD_VALUE:      pad = val[7:0];
        REG_CAPACITY:       capacity = val[11:0];
        REG_TIMEOUT_BUDGET: budget = val[15:0];
        default: ;
      endcase
    endfunction

    function void emit(kind_t k, logic [7:0] v, logic [11:0] idx, status_t st,
                       logic [11:0] len);
      beat_t b;
      b.kind = k;
      b.value = v;
      b.index = idx;
      b.status = st;
      b.length = len;
      b.last = 1'b0;
      fresh.push_back(b);
    endfunction

    function void conclude(status_t st, logic [11:0] len);
      emit(KIND_DONE, 8'd0, 12'd0, st, (st == ST_OK) ? len : 12'd0);
      phase = PH_IDLE;
    endfunction

    function void on_frame(logic [3:0] dlc_in, frame_bytes_t d);
      int dlc, len, rem, take, lim, i;
      logic [3:0] ftype;
      ftype = d[0][7:4];
      dlc = (dlc_in > DLC_FULL) ? 8 : int'(dlc_in);
      lim = (int'(capacity) < MSG_LIMIT) ? int'(capacity) : MSG_LIMIT;
      if (dlc < 1) begin
        conclude(ST_INVALID, 12'd0);
      end else if (phase == PH_FIRST) begin
        if (ftype == FT_SINGLE) begin
          len = d[0][3:0];
          if (len == 0 || len > int'(SF_PAYLOAD_MAX) || len > dlc - 1) begin
            conclude(ST_INVALID, 12'd0);
          end else if (len > lim) begin
            conclude(ST_OVERRUN, 12'd0);
          end else begin
            for (i = 0; i < len; i++) emit(KIND_PAYLOAD, d[1 + i], 12'(i), ST_OK, 12'd0);
            conclude(ST_OK, 12'(len));
          end
        end else if (ftype != FT_FIRST || dlc < 8) begin
          conclude(ST_INVALID, 12'd0);
        end else begin
          total_len = {d[0][3:0], d[1]};
          if (total_len <= 12'd7) begin
            conclude(ST_INVALID, 12'd0);
          end else if (int'(total_len) > lim) begin
            conclude(ST_OVERRUN, 12'd0);
          end else begin
            for (i = 0; i < int'(FF_PAYLOAD); i++) begin
              emit(KIND_PAYLOAD, d[2 + i], 12'(i), ST_OK, 12'd0);
            end
            emit(KIND_FLOW, FC_CLEAR, 12'd0, ST_OK, 12'd0);
            emit(KIND_FLOW, FC_BLOCK_SIZE, 12'd1, ST_OK, 12'd0);
            emit(KIND_FLOW, FC_ST_MIN, 12'd2, ST_OK, 12'd0);
            for (i = 3; i <= int'(FC_LAST_BYTE); i++) emit(KIND_FLOW, pad, 12'(i), ST_OK, 12'd0);
            rcvd = 12'd6;
            next_seq = 4'd1;
            phase = PH_CONSEC;
          end
        end
      end else if (ftype != FT_CONSEC) begin
        conclude(ST_INVALID, 12'd0);
      end else if (d[0][3:0] != next_seq) begin
        conclude(ST_SEQUENCE, 12'd0);
      end else begin
        rem = (total_len > rcvd) ? int'(total_len) - int'(rcvd) : 0;
        take = (rem < int'(CF_PAYLOAD_MAX)) ? rem : int'(CF_PAYLOAD_MAX);
        if (dlc < 1 + take) begin
          conclude(ST_INVALID, 12'd0);
        end else begin
          for (i = 0; i < take; i++) emit(KIND_PAYLOAD, d[1 + i], rcvd + 12'(i), ST_OK, 12'd0);
          rcvd = rcvd + 12'(take);
          next_seq = next_seq + 4'd1;
          if (rcvd >= total_len) conclude(ST_OK, rcvd);
        end
      end
    endfunction

    // Notes one accepted input beat; returns whether the block acted on it.
    function bit take_item(logic [1:0] op, logic [28:0] id, logic [3:0] dlc,
                           frame_bytes_t d);
      bit counted;
      counted = 1'b0;
      fresh.delete();
      case (op)
        OP_START: begin
          counted = 1'b1;
          phase = PH_FIRST;
          time_left = budget;
          total_len = '0;
          rcvd = '0;
          next_seq = 4'd1;
          if (time_left == 16'd0) conclude(ST_TIMEOUT, 12'd0);
        end
        OP_TICK: begin
          if (phase != PH_IDLE) begin
            counted = 1'b1;
            if (time_left > 16'd0) time_left--;
            if (time_left == 16'd0) conclude(ST_TIMEOUT, 12'd0);
          end
        end
        OP_FRAME: begin
          if (phase != PH_IDLE && id == rsp_id) begin
            counted = 1'b1;
            on_frame(dlc, d);
          end
        end
        default: ;
      endcase
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) awaited.push_back(fresh[i]);
      return counted;
    endfunction

    task complain(string what);
      mismatches++;
      $display("ERROR at beat %0d: %s", beats_seen, what);
    endtask

    task compare(string field, logic [11:0] got, logic [11:0] want);
      if (got !== want) complain($sformatf("%s is %0h, expected %0h", field, got, want));
    endtask

    task check_beat(logic [1:0] kind, logic [39:0] data, logic last);
      beat_t want;
      beats_seen++;
      if (awaited.size() == 0) begin
        complain($sformatf("unexpected beat, kind %0d data %h", kind, data));
      end else begin
        want = awaited.pop_front();
        compare("kind", 12'(kind), 12'(want.kind));
        compare("byte_value", 12'(data[7:0]), 12'(want.value));
        compare("byte_index", data[19:8], want.index);
        compare("status", 12'(data[22:20]), 12'(want.status));
        compare("message_length", data[34:23], want.length);
        compare("last", 12'(last), 12'(want.last));
        if (want.kind == KIND_DONE) endings[int'(want.status)]++;
      end
    endtask
  endclass

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [28:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [103:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [39:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  reassembly_scoreboard board;
  logic [28:0] rsp_id;
  bit          calm;
  bit          hold_req;
  int          items_done;
  int          settings_done;

  can_transport_reassembling_receiver dut (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_beat(m_tuser, m_tdata, m_tlast);
  end

  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm || $urandom_range(2) != 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  function automatic frame_bytes_t noise_bytes();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [3:0] dlc_for(int need);
    return ($urandom_range(3) != 0) ? 4'(need) : 4'($urandom_range(need, 15));
  endfunction

  task automatic offer(logic [1:0] op, logic [28:0] id, logic [3:0] dlc, frame_bytes_t d);
    if (!calm && !hold_req && $urandom_range(3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'd0, d, dlc, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (board.take_item(op, id, dlc, d)) items_done++;
  endtask

  task automatic start_session();
    offer(OP_START, 29'($urandom), 4'($urandom), noise_bytes());
  endtask

  task automatic tick();
    offer(OP_TICK, 29'($urandom), 4'($urandom), noise_bytes());
  endtask

  task automatic send_frame(logic [3:0] dlc, frame_bytes_t d);
    offer(OP_FRAME, rsp_id, dlc, d);
  endtask

  task automatic single_frame(int len, logic [3:0] dlc);
    frame_bytes_t b;
    b = noise_bytes();
    b[0] = {FT_SINGLE, 4'(len)};
    send_frame(dlc, b);
  endtask

  task automatic first_frame(int len, logic [3:0] dlc);
    frame_bytes_t b;
    b = noise_bytes();
    b[0] = {FT_FIRST, 4'(len >> 8)};
    b[1] = 8'(len);
    send_frame(dlc, b);
  endtask

  task automatic noise_item();
    case ($urandom_range(3))
      0: offer(OP_FRAME, rsp_id ^ 29'($urandom_range(1, 2 ** 29 - 1)), 4'($urandom),
               noise_bytes());
      1: offer(OP_UNUSED, 29'($urandom), 4'($urandom), noise_bytes());
      2: tick();
      default: send_frame(4'($urandom), noise_bytes());
    endcase
  endtask

  task automatic segmented(int len, fault_t fault, int tick_pct);
    frame_bytes_t b;
    int got, take, at, spot, t;
    logic [3:0] seq;
    if (fault == FAULT_FIRST_DLC) begin
      first_frame(len, 4'($urandom_range(1, 7)));
      return;
    end
    first_frame(len, dlc_for(8));
    got = 6;
    at = 0;
    seq = 4'd1;
    spot = $urandom_range(0, len / 7 - 1);
    while (got < len) begin
      if ($urandom_range(99) < tick_pct) tick();
      take = (len - got < int'(CF_PAYLOAD_MAX)) ? len - got : int'(CF_PAYLOAD_MAX);
      b = noise_bytes();
      b[0] = {FT_CONSEC, seq};
      if (fault != FAULT_NONE && at == spot) begin
        case (fault)
          FAULT_SEQ: begin
            b[0][3:0] = seq + 4'($urandom_range(1, 15));
            send_frame(dlc_for(1 + take), b);
          end
          FAULT_TYPE: begin
            t = $urandom_range(0, 14);
            if (t >= int'(FT_CONSEC)) t++;
            b[0][7:4] = 4'(t);
            send_frame(dlc_for(1 + take), b);
          end
          FAULT_DLC: send_frame(4'($urandom_range(0, take)), b);
          default: ;
        endcase
        return;
      end
      send_frame(dlc_for(1 + take), b);
      got += take;
      seq++;
      at++;
    end
  endtask

  task automatic random_session(int tick_pct);
    int r, len;
    start_session();
    if ($urandom_range(99) < 20) noise_item();
    r = $urandom_range(99);
    if (r < 35) begin
      if ($urandom_range(9) == 0) begin
        single_frame($urandom_range(0, 15), 4'($urandom));
      end else begin
        len = $urandom_range(1, 7);
        single_frame(len, dlc_for(len + 1));
      end
    end else if (r < 85) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(41, 400) : $urandom_range(8, 40);
      segmented(len, ($urandom_range(99) < 25) ?
                fault_t'($urandom_range(FAULT_SEQ, FAULT_FIRST_DLC)) : FAULT_NONE, tick_pct);
    end else begin
      send_frame(4'($urandom), noise_bytes());
    end
    if ($urandom_range(99) < 10) noise_item();
  endtask

  task automatic write_registers(logic [28:0] rid, logic [28:0] qid, logic [7:0] pad,
                                 logic [11:0] cap, logic [15:0] bud);
    reg_index_t order[5] = '{REG_RESPONSE_ID, REG_REQUEST_ID, REG_PAD_VALUE,
                             REG_CAPACITY, REG_TIMEOUT_BUDGET};
    logic [28:0] vals[5];
    vals = '{rid, qid, 29'(pad), 29'(cap), 29'(bud)};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= order[i];
      cfg_data <= vals[i];
      board.set_reg(order[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    rsp_id = rid;
    settings_done++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (board.awaited.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int round, goal;
    board = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_RESPONSE_ID;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= OP_START;
    calm = 1'b0;
    hold_req = 1'b0;
    items_done = 0;
    settings_done = 0;
    rsp_id = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_registers(29'h18DAF110, 29'h18DA10F1, 8'hAA, 12'd4095, 16'd1000);
    tick();
    single_frame(3, 4'd4);
    start_session();
    offer(OP_FRAME, rsp_id ^ 29'h1, 4'd8, noise_bytes());
    offer(OP_UNUSED, rsp_id, 4'd8, noise_bytes());
    single_frame(7, 4'd8);
    start_session();
    single_frame(3, 4'd15);
    start_session();
    single_frame(0, 4'd8);
    start_session();
    send_frame(4'd0, noise_bytes());
    start_session();
    segmented(20, FAULT_NONE, 0);
    start_session();
    segmented(13, FAULT_SEQ, 0);
    start_session();
    first_frame(7, 4'd8);
    start_session();
    first_frame(4095, 4'd8);
    start_session();
    single_frame(4, 4'd5);
    settle();

    write_registers(29'h1FFFFFFF, 29'h1FFFFFFF, 8'h55, 12'd5, 16'd2);
    start_session();
    tick();
    tick();
    start_session();
    single_frame(6, 4'd7);
    start_session();
    first_frame(8, 4'd8);
    settle();
    write_registers(29'd0, 29'd0, 8'h00, 12'd0, 16'd0);
    start_session();
    settle();

    for (round = 0; round < 6; round++) begin
      case (round)
        0: write_registers(29'd0, 29'd0, 8'h00, 12'd4095, 16'hFFFF);
        1: write_registers(29'h1FFFFFFF, 29'h1FFFFFFF, 8'hFF, 12'd0, 16'd1);
        default: write_registers(29'($urandom), 29'($urandom), 8'($urandom),
                                 ($urandom_range(3) == 0) ? 12'd4095 :
                                 12'($urandom_range(6, 600)),
                                 16'($urandom_range(2, 60)));
      endcase
      if (round == 3) hold_req = 1'b1;
      calm = (round == 5);
      goal = items_done + ((round == 1) ? 30 : 68);
      while (items_done < goal) random_session((round == 0) ? 0 : 10);
      settle();
    end

    $display("Ran %0d effective input beats over %0d register settings, %0d output beats.",
             items_done, settings_done, board.beats_seen);
    $display("Completions: ok %0d, timeout %0d, invalid %0d, overrun %0d, sequence %0d.",
             board.endings[ST_OK], board.endings[ST_TIMEOUT], board.endings[ST_INVALID],
             board.endings[ST_OVERRUN], board.endings[ST_SEQUENCE]);
    if (board.mismatches == 0 && board.awaited.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
